// ----- design/kvt_pkg.sv -----
package kvt_pkg;

  // Default sizes of the table.
  localparam int DEPTH_DEF      = 128;
  localparam int KEY_BITS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Fixed field widths.
  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 8;

  // Opcodes.
  localparam logic [OP_W-1:0] OP_SET    = 3'd0;
  localparam logic [OP_W-1:0] OP_GET    = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
  localparam logic [OP_W-1:0] OP_REWIND = 3'd4;
  localparam logic [OP_W-1:0] OP_COUNT  = 3'd5;
  localparam logic [OP_W-1:0] OP_INIT   = 3'd6;
  localparam logic [OP_W-1:0] OP_FINI   = 3'd7;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTREADY = 2'd3;

  // Flags of the token that walks down the row of slots.
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [CNT_W-1:0] cnt;
  } kvt_tok_t;

  // Command broadcast to every slot.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            clear;
  } kvt_cmd_t;

endpackage

// ----- design/kvt_cell.sv -----
module kvt_cell import kvt_pkg::*; #(
  parameter int IDX        = 0,
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  kvt_cmd_t                       cmd,
  input  logic [KEY_BITS-1:0]            cmd_key,
  input  logic [VALUE_BITS-1:0]          cmd_value,
  input  logic [$clog2(DEPTH+1)-1:0]     slots_used,
  input  logic [$clog2(DEPTH+1)-1:0]     cursor,
  input  kvt_tok_t                       tok_in,
  input  logic [VALUE_BITS-1:0]          vout_in,
  input  logic [KEY_BITS-1:0]            kout_in,
  input  logic [$clog2(DEPTH+1)-1:0]     pos_in,
  output kvt_tok_t                       tok_out,
  output logic [VALUE_BITS-1:0]          vout_out,
  output logic [KEY_BITS-1:0]            kout_out,
  output logic [$clog2(DEPTH+1)-1:0]     pos_out
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] IDX_V = CW'(IDX);
  localparam logic [CW-1:0] POS_V = CW'(IDX + 1);

  // Slot contents.
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic                  live;

  logic match;
  logic at_append;
  logic past_cursor;

  kvt_tok_t              tok_next;
  logic [VALUE_BITS-1:0] vout_next;
  logic [KEY_BITS-1:0]   kout_next;
  logic [CW-1:0]         pos_next;

  assign match       = live && (key == cmd_key);
  assign at_append   = (IDX_V == slots_used);
  assign past_cursor = (IDX_V >= cursor);

  // Work of this slot on the passing token.
  always_comb begin
    tok_next  = tok_in;
    vout_next = vout_in;
    kout_next = kout_in;
    pos_next  = pos_in;
    if (tok_in.active) begin
      case (cmd.op)
        OP_SET, OP_GET, OP_DELETE: begin
          if (match) begin
            tok_next.hit = 1'b1;
            vout_next    = value;
          end
        end
        OP_NEXT: begin
          if (!tok_in.hit && live && past_cursor) begin
            tok_next.hit = 1'b1;
            kout_next    = key;
            pos_next     = POS_V;
          end
        end
        OP_COUNT: begin
          tok_next.cnt = tok_in.cnt + CNT_W'(live);
        end
        default: begin
        end
      endcase
    end
  end

  // Token hand-off to the next slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
    vout_out <= vout_next;
    kout_out <= kout_next;
    pos_out  <= pos_next;
  end

  // Live flag: cleared by reset and init, set by append, cleared by delete.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      live <= 1'b0;
    end else if (tok_in.active) begin
      if (cmd.op == OP_DELETE && match) begin
        live <= 1'b0;
      end else if (cmd.op == OP_SET && !tok_in.hit && !match && at_append) begin
        live <= 1'b1;
      end
    end
  end

  // Key and value words: update in place or append.
  always_ff @(posedge clk) begin
    if (tok_in.active && cmd.op == OP_SET) begin
      if (match) begin
        value <= cmd_value;
      end else if (!tok_in.hit && at_append) begin
        key   <= cmd_key;
        value <= cmd_value;
      end
    end
  end

endmodule

// ----- design/key_value_table_linear.sv -----
// Key/value table of DEPTH slots, built as a row of slot cells that a
// command token walks through, one slot per clock cycle. Set, get, delete,
// next and count send the token down the whole row; the result word is
// formed when the token leaves the last slot. Rewind, init, fini and any
// command refused because the table is not ready go straight to the result
// without a sweep. One word is worked on at a time; a finished result waits
// in the output register while the next word is accepted. A set of a new
// key on a full table answers status full and is dropped; set, get, delete
// and next before init answer status not ready.
module key_value_table_linear import kvt_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IN_W  = ((OP_W + KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((STATUS_W + VALUE_BITS + KEY_BITS + CNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // Fields from bit 0 up: opcode, key, value, zero fill.
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // Fields from bit 0 up: status, value_out, key_out, live_count, zero fill.
  output logic [OUT_W-1:0] m_tdata
);

  localparam int CW = $clog2(DEPTH+1);
  localparam logic [CW-1:0] DEPTH_V = CW'(DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DONE  = 2'd2;

  logic [1:0] state;

  // Table-wide state and the held command.
  logic                  ready_flag;
  logic [CW-1:0]         slots_used;
  logic [CW-1:0]         cursor;
  logic                  launch;
  logic [OP_W-1:0]       cmd_op;
  logic [KEY_BITS-1:0]   cmd_key;
  logic [VALUE_BITS-1:0] cmd_value;

  // Input word fields.
  logic [OP_W-1:0]       in_op;
  logic [KEY_BITS-1:0]   in_key;
  logic [VALUE_BITS-1:0] in_value;
  assign in_op    = s_tdata[OP_W-1:0];
  assign in_key   = s_tdata[OP_W +: KEY_BITS];
  assign in_value = s_tdata[OP_W+KEY_BITS +: VALUE_BITS];

  logic accept;
  logic lookup_op;
  logic needs_sweep;
  assign s_tready    = (state == S_IDLE);
  assign accept      = s_tvalid && s_tready;
  assign lookup_op   = (in_op == OP_SET) || (in_op == OP_GET) ||
                       (in_op == OP_DELETE) || (in_op == OP_NEXT);
  assign needs_sweep = (in_op == OP_COUNT) || (ready_flag && lookup_op);

  // Result waiting for the output register.
  logic [STATUS_W-1:0]   res_status;
  logic [VALUE_BITS-1:0] res_vout;
  logic [KEY_BITS-1:0]   res_kout;
  logic [CNT_W-1:0]      res_cnt;

  // Chain of slots.
  kvt_cmd_t              cmd;
  kvt_tok_t              tok    [0:DEPTH];
  logic [VALUE_BITS-1:0] vout_c [0:DEPTH];
  logic [KEY_BITS-1:0]   kout_c [0:DEPTH];
  logic [CW-1:0]         pos_c  [0:DEPTH];

  assign cmd.op    = cmd_op;
  assign cmd.clear = accept && (in_op == OP_INIT);

  assign tok[0].active = launch;
  assign tok[0].hit    = 1'b0;
  assign tok[0].cnt    = '0;
  assign vout_c[0]     = '0;
  assign kout_c[0]     = '0;
  assign pos_c[0]      = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    kvt_cell #(
      .IDX        (i),
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .cmd_key    (cmd_key),
      .cmd_value  (cmd_value),
      .slots_used (slots_used),
      .cursor     (cursor),
      .tok_in     (tok[i]),
      .vout_in    (vout_c[i]),
      .kout_in    (kout_c[i]),
      .pos_in     (pos_c[i]),
      .tok_out    (tok[i+1]),
      .vout_out   (vout_c[i+1]),
      .kout_out   (kout_c[i+1]),
      .pos_out    (pos_c[i+1])
    );
  end

  logic tail;
  logic out_free;
  assign tail     = tok[DEPTH].active;
  assign out_free = !m_tvalid || m_tready;

  // Sequencer and table-wide state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      launch     <= 1'b0;
      ready_flag <= 1'b0;
      slots_used <= '0;
      cursor     <= '0;
    end else begin
      launch <= accept && needs_sweep;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (needs_sweep) begin
              state <= S_SWEEP;
            end else begin
              state <= S_DONE;
              case (in_op)
                OP_REWIND: cursor <= '0;
                OP_INIT: begin
                  ready_flag <= 1'b1;
                  slots_used <= '0;
                  cursor     <= '0;
                end
                OP_FINI: ready_flag <= 1'b0;
                default: begin
                end
              endcase
            end
          end
        end
        S_SWEEP: begin
          if (tail) begin
            state <= S_DONE;
            if (cmd_op == OP_SET && !tok[DEPTH].hit && slots_used != DEPTH_V) begin
              slots_used <= slots_used + 1'b1;
            end
            if (cmd_op == OP_NEXT) begin
              if (tok[DEPTH].hit) begin
                cursor <= pos_c[DEPTH];
              end else if (cursor < slots_used) begin
                cursor <= slots_used;
              end
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Held command and the result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op     <= in_op;
      cmd_key    <= in_key;
      cmd_value  <= in_value;
      res_status <= (lookup_op && !ready_flag) ? ST_NOTREADY : ST_OK;
      res_vout   <= '0;
      res_kout   <= '0;
      res_cnt    <= '0;
    end else if (state == S_SWEEP && tail) begin
      res_vout <= ((cmd_op == OP_SET) || (cmd_op == OP_GET)) ? vout_c[DEPTH] : '0;
      res_kout <= kout_c[DEPTH];
      res_cnt  <= (cmd_op == OP_COUNT) ? tok[DEPTH].cnt : '0;
      if (cmd_op == OP_COUNT) begin
        res_status <= ST_OK;
      end else if (tok[DEPTH].hit) begin
        res_status <= ST_OK;
      end else if (cmd_op == OP_SET) begin
        res_status <= (slots_used == DEPTH_V) ? ST_FULL : ST_OK;
      end else begin
        res_status <= ST_MISS;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= OUT_W'({res_cnt, res_kout, res_vout, res_status});
    end
  end

  // Checks on the table state and the sequencer.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= DEPTH_V)
    else $error("slot count beyond depth");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    cursor <= slots_used)
    else $error("cursor beyond slots in use");

  a_tail_in_sweep: assert property (@(posedge clk) disable iff (rst)
    tail |-> state == S_SWEEP)
    else $error("token left the row outside a sweep");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("accepted word was not taken up");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import kvt_pkg::*;

  localparam int SLOTS       = DEPTH_DEF;
  localparam int KW          = KEY_BITS_DEF;
  localparam int VW          = VALUE_BITS_DEF;
  // A full scan of the slot row, plus the token's own overhead.
  localparam int SCAN_CYCLES = SLOTS + 3;
  localparam int RUN_LIMIT   = 2_000_000;
  localparam int POOL_SIZE   = 12;
  localparam int MAX_REPORTS = 10;

  // Command word, fields listed from the top bit down.
  typedef struct packed {
    logic [4:0]      fill;
    logic [VW-1:0]   value;
    logic [KW-1:0]   key;
    logic [OP_W-1:0] op;
  } cmd_word_t;

  // Reply word, fields listed from the top bit down.
  typedef struct packed {
    logic [5:0]          fill;
    logic [CNT_W-1:0]    live_count;
    logic [KW-1:0]       key_out;
    logic [VW-1:0]       value_out;
    logic [STATUS_W-1:0] status;
  } reply_word_t;

  logic                           clk      = 1'b0;
  logic                           rst      = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [$bits(cmd_word_t)-1:0]   s_tdata  = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [$bits(reply_word_t)-1:0] m_tdata;

  key_value_table_linear uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Shadow copy of the table contents.
  logic [KW-1:0] slot_key [SLOTS];
  logic [VW-1:0] slot_val [SLOTS];
  bit            slot_on  [SLOTS];
  int unsigned   slots_taken = 0;
  int unsigned   walk_pos    = 0;
  bit            table_open  = 1'b0;

  reply_word_t   awaited_replies [$];

  int            send_idle_pct = 9;
  int            recv_idle_pct = 47;
  int            commands_sent = 0;
  int            replies_seen  = 0;
  int            mismatch_count = 0;
  int            input_stalls  = 0;
  int            status_seen [4] = '{0, 0, 0, 0};

  event          hold_start;
  int            hold_len      = 0;
  bit            receiver_held = 1'b0;

  always #2 clk = ~clk;

  // Returns the index of the live slot holding k, or SLOTS when none does.
  function automatic int unsigned find_live_slot(logic [KW-1:0] k);
    int unsigned found;
    found = SLOTS;
    for (int unsigned i = 0; i < slots_taken; i++) begin
      if (found == SLOTS && slot_on[i] && slot_key[i] == k) found = i;
    end
    return found;
  endfunction

  // Applies one command to the shadow table and returns the reply it earns.
  function automatic reply_word_t apply_command(cmd_word_t c);
    reply_word_t r;
    int unsigned hit;
    bit          got_key;
    r = '0;
    r.status = ST_OK;
    if (!table_open && c.op <= OP_NEXT) begin
      r.status = ST_NOTREADY;
    end else begin
      case (c.op)
        OP_SET: begin
          hit = find_live_slot(c.key);
          if (hit < SLOTS) begin
            r.value_out   = slot_val[hit];
            slot_val[hit] = c.value;
          end else if (slots_taken >= SLOTS) begin
            r.status = ST_FULL;
          end else begin
            slot_key[slots_taken] = c.key;
            slot_val[slots_taken] = c.value;
            slot_on[slots_taken]  = 1'b1;
            slots_taken++;
          end
        end
        OP_GET: begin
          hit = find_live_slot(c.key);
          if (hit < SLOTS) r.value_out = slot_val[hit];
          else r.status = ST_MISS;
        end
        OP_DELETE: begin
          hit = find_live_slot(c.key);
          if (hit < SLOTS) slot_on[hit] = 1'b0;
          else r.status = ST_MISS;
        end
        OP_NEXT: begin
          // Walk forward to the next live slot; the cursor stops at the end.
          r.status = ST_MISS;
          got_key  = 1'b0;
          while (!got_key && walk_pos < slots_taken) begin
            if (slot_on[walk_pos]) begin
              r.key_out = slot_key[walk_pos];
              r.status  = ST_OK;
              got_key   = 1'b1;
            end
            walk_pos++;
          end
        end
        OP_REWIND: begin
          walk_pos = 0;
        end
        OP_COUNT: begin
          for (int unsigned i = 0; i < slots_taken; i++) begin
            if (slot_on[i]) r.live_count = r.live_count + 1'b1;
          end
        end
        OP_INIT: begin
          table_open  = 1'b1;
          slots_taken = 0;
          walk_pos    = 0;
        end
        default: begin
          table_open = 1'b0;
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [KW-1:0] random_key();
    return {$urandom, $urandom};
  endfunction

  // Offers one command word, starting and ending at a falling edge.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [KW-1:0] key,
                              input logic [VW-1:0] value);
    cmd_word_t c;
    c       = '0;
    c.op    = op;
    c.key   = key;
    c.value = value;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    awaited_replies.push_back(apply_command(c));
    commands_sent++;
    @(negedge clk);
  endtask

  task automatic flag_error(input string what, input logic [KW-1:0] want,
                            input logic [KW-1:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [KW-1:0] want,
                             input logic [KW-1:0] got);
    if (want !== got) flag_error(what, want, got);
  endtask

  // Compare every reply word with the oldest expectation.
  always @(posedge clk) begin : check_replies
    reply_word_t got;
    reply_word_t want;
    if (!rst && s_tvalid && !s_tready) input_stalls++;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      replies_seen++;
      if (awaited_replies.size() == 0) begin
        flag_error("unexpected reply word", '0, m_tdata[KW-1:0]);
      end else begin
        want = awaited_replies.pop_front();
        status_seen[want.status]++;
        check_field("status", KW'(want.status), KW'(got.status));
        check_field("value_out", KW'(want.value_out), KW'(got.value_out));
        check_field("key_out", want.key_out, got.key_out);
        check_field("live_count", KW'(want.live_count), KW'(got.live_count));
        check_field("zero fill", KW'(want.fill), KW'(got.fill));
      end
    end
  end

  // Long receiver hold-off, counted here in clock cycles.
  always begin
    @(hold_start);
    @(posedge clk);
    receiver_held = 1'b1;
    repeat (hold_len) @(posedge clk);
    receiver_held = 1'b0;
  end

  // Receiver readiness, random except during a hold-off.
  always @(negedge clk) begin
    m_tready <= !receiver_held && ($urandom_range(99) >= recv_idle_pct);
  end

  // Set, get, delete and next are refused before init; the rest still work.
  task automatic test_before_init();
    send_command(OP_SET, '1, '1);
    send_command(OP_GET, '1, '0);
    send_command(OP_DELETE, '0, '1);
    send_command(OP_NEXT, random_key(), $urandom);
    send_command(OP_COUNT, random_key(), $urandom);
    send_command(OP_REWIND, random_key(), $urandom);
    send_command(OP_FINI, random_key(), $urandom);
  endtask

  // Field extremes, update versus append, misses, deleted slots and the cursor.
  task automatic test_table_ops();
    send_command(OP_INIT, '0, '0);
    send_command(OP_SET, '1, '1);
    send_command(OP_SET, '0, '0);
    send_command(OP_SET, '0, 32'h5555_5555);
    send_command(OP_GET, '1, '0);
    send_command(OP_GET, 64'h0123_4567_89ab_cdef, '0);
    send_command(OP_DELETE, '0, '0);
    send_command(OP_GET, '0, '0);
    send_command(OP_DELETE, '0, '0);
    send_command(OP_COUNT, '0, '0);
    send_command(OP_REWIND, '0, '0);
    send_command(OP_NEXT, '0, '0);
    send_command(OP_NEXT, '0, '0);
    send_command(OP_NEXT, '0, '0);
    // A deleted key comes back in a fresh slot.
    send_command(OP_SET, '0, 32'haaaa_aaaa);
    send_command(OP_COUNT, '0, '0);
    send_command(OP_FINI, '0, '0);
    send_command(OP_GET, '1, '0);
  endtask

  // Fill every slot, then probe the full table and a re-init.
  task automatic test_full_table();
    logic [KW-1:0] filled [SLOTS];
    logic [KW-1:0] spare;
    send_command(OP_INIT, random_key(), $urandom);
    for (int i = 0; i < SLOTS; i++) begin
      filled[i] = random_key();
      send_command(OP_SET, filled[i], $urandom);
    end
    spare = random_key();
    send_command(OP_SET, spare, $urandom);
    send_command(OP_SET, filled[5], $urandom);
    send_command(OP_DELETE, filled[5], $urandom);
    send_command(OP_SET, spare, $urandom);
    send_command(OP_GET, filled[SLOTS-1], $urandom);
    send_command(OP_COUNT, random_key(), $urandom);
    send_command(OP_REWIND, random_key(), $urandom);
    for (int i = 0; i < 7; i++) send_command(OP_NEXT, random_key(), $urandom);
    send_command(OP_INIT, random_key(), $urandom);
    send_command(OP_GET, filled[0], $urandom);
    send_command(OP_COUNT, random_key(), $urandom);
  endtask

  // The receiver stops for several scan times while words keep coming.
  task automatic test_receiver_hold();
    logic [KW-1:0] k;
    send_idle_pct = 0;
    hold_len = 4 * SCAN_CYCLES;
    -> hold_start;
    k = random_key();
    send_command(OP_SET, k, $urandom);
    send_command(OP_GET, k, $urandom);
    send_command(OP_COUNT, random_key(), $urandom);
    send_command(OP_NEXT, random_key(), $urandom);
    send_command(OP_REWIND, random_key(), $urandom);
    send_command(OP_SET, k, $urandom);
    send_command(OP_GET, k, $urandom);
    send_command(OP_COUNT, random_key(), $urandom);
  endtask

  // Mostly valid traffic on a small key set, with stray keys and fini mixed in.
  task automatic test_random_mix(input int n);
    logic [KW-1:0]   key_pool [POOL_SIZE];
    logic [KW-1:0]   k;
    logic [OP_W-1:0] op;
    int unsigned     pick;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();
    send_command(OP_INIT, random_key(), $urandom);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 34) op = OP_SET;
      else if (pick < 58) op = OP_GET;
      else if (pick < 68) op = OP_DELETE;
      else if (pick < 80) op = OP_NEXT;
      else if (pick < 86) op = OP_REWIND;
      else if (pick < 94) op = OP_COUNT;
      else if (pick < 97) op = OP_INIT;
      else op = OP_FINI;
      // Recover quickly after fini so that most words reach the table.
      if (!table_open && $urandom_range(3) != 0) op = OP_INIT;
      if ($urandom_range(4) != 0) k = key_pool[$urandom_range(POOL_SIZE - 1)];
      else k = random_key();
      send_command(op, k, $urandom);
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_before_init();
    test_table_ops();
    test_full_table();
    test_receiver_hold();
    send_idle_pct = 9;
    recv_idle_pct = 47;
    test_random_mix(110);
    send_idle_pct = 47;
    recv_idle_pct = 9;
    test_random_mix(110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(100);
    // Let the last replies drain, then watch for stray words.
    s_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk);
    repeat (SCAN_CYCLES + 10) @(negedge clk);
    $display("Sent %0d command words over all eight opcodes; checked %0d replies.",
             commands_sent, replies_seen);
    $display("Statuses ok %0d, miss %0d, full %0d, not ready %0d; %0d stall cycles, %0d errors.",
             status_seen[ST_OK], status_seen[ST_MISS], status_seen[ST_FULL],
             status_seen[ST_NOTREADY], input_stalls, mismatch_count);
    if (mismatch_count == 0 && awaited_replies.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("Timed out with %0d replies still awaited.", awaited_replies.size());
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/kvt_pkg.sv
design/kvt_cell.sv
design/key_value_table_linear.sv
tb/sv/testbench.sv
